### hw/rtl/lav_pkg.sv
// Shared types and constants for the look-at view matrix block.
// No dependencies; used by every module under hw/rtl.
package lav_pkg;

  localparam int IN_W       = 32;  // input component width
  localparam int MAG_W      = 32;  // magnitude of a vector component
  localparam int SQ_W       = 64;  // squared length
  localparam int SQRT_STEPS = 32;  // one root bit per step
  localparam int PROJ_W     = 35;  // projected up component
  localparam int ENTRY_W    = 40;  // matrix entry width
  localparam int ROW_W      = 2;

  typedef logic [ROW_W-1:0] row_idx_t;
  localparam row_idx_t ROW_FIRST = 2'd0;
  localparam row_idx_t ROW_LAST  = 2'd3;

  typedef logic signed [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    entry_t e0;
    entry_t e1;
    entry_t e2;
    entry_t e3;
  } row_t;

endpackage

### hw/rtl/lav_norm.sv
// Pipelined vector normalizer: squares, 32-step root, restoring division.
// Depends on lav_pkg. Shared enable stalls every stage; side data rides along.
module lav_norm #(
  parameter int FRAC_BITS = 16,
  parameter int AW        = 33,
  parameter int SW        = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  logic signed [AW-1:0]    in_a [3],
  input  logic [SW-1:0]           in_side,
  output logic                    out_v,
  output logic signed [FRAC_BITS+1:0] out_q [3],
  output logic                    out_zero,
  output logic [SW-1:0]           out_side
);

  localparam int MW = lav_pkg::MAG_W;
  localparam int QW = FRAC_BITS + 2;
  localparam int NQ = FRAC_BITS + 1;       // quotient bits
  localparam int DW = FRAC_BITS + 34;      // dividend width
  localparam int SQ = lav_pkg::SQRT_STEPS;
  localparam int NL = SQ + NQ + 5;         // total stages

  logic [NL-1:0]              vld_r;
  logic [SW-1:0]              side_r [NL];

  logic [2:0][MW-1:0]         mag_a_nxt, mag_a_r, mag_b_r;
  logic [2:0]                 neg_a_nxt, neg_a_r, neg_b_r;
  logic [2:0][lav_pkg::SQ_W-1:0] sq_b_nxt, sq_b_r;

  logic [lav_pkg::SQ_W-1:0]   sx_r [SQ+1];
  logic [lav_pkg::SQ_W-1:0]   sr_r [SQ+1];
  logic [2:0][MW-1:0]         sm_r [SQ+1];
  logic [2:0]                 sn_r [SQ+1];

  logic [MW-1:0]              root;
  logic [2:0][DW-1:0]         num_nxt;
  logic [2:0][DW-1:0]         dr_r [NQ+1];
  logic [2:0][NQ-1:0]         dq_r [NQ+1];
  logic [MW-1:0]              dn_r [NQ+1];
  logic [2:0]                 dg_r [NQ+1];
  logic                       dz_r [NQ+1];

  logic signed [QW-1:0]       q_nxt [3];
  logic signed [QW-1:0]       q_e_r [3];
  logic                       z_e_r;

  // valid bits, reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NL-2:0], in_v};
    end
  end

  // side data delay line
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int i = 1; i < NL; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // magnitudes and signs
  always_comb begin
    logic signed [AW-1:0] m;
    m = '0;
    for (int i = 0; i < 3; i++) begin
      neg_a_nxt[i] = in_a[i][AW-1];
      m            = neg_a_nxt[i] ? -in_a[i] : in_a[i];
      mag_a_nxt[i] = m[MW-1:0];
    end
  end

  // squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_b_nxt[i] = mag_a_r[i] * mag_a_r[i];
    end
  end

  // stages a, b and the squared length
  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r  <= mag_a_nxt;
      neg_a_r  <= neg_a_nxt;
      sq_b_r   <= sq_b_nxt;
      mag_b_r  <= mag_a_r;
      neg_b_r  <= neg_a_r;
      sx_r[0]  <= sq_b_r[0] + sq_b_r[1] + sq_b_r[2];
      sr_r[0]  <= '0;
      sm_r[0]  <= mag_b_r;
      sn_r[0]  <= neg_b_r;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [lav_pkg::SQ_W-1:0] BIT = lav_pkg::SQ_W'(1) << (62 - 2 * k);
    logic [lav_pkg::SQ_W-1:0] trial;
    logic                     take;
    assign trial = sr_r[k] + BIT;
    assign take  = sx_r[k] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sx_r[k+1] <= take ? sx_r[k] - trial : sx_r[k];
        sr_r[k+1] <= take ? (sr_r[k] >> 1) + BIT : sr_r[k] >> 1;
        sm_r[k+1] <= sm_r[k];
        sn_r[k+1] <= sn_r[k];
      end
    end
  end

  // dividend: mag * 2^F plus half the divisor for rounding
  assign root = sr_r[SQ][MW-1:0];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = (DW'(sm_r[SQ][i]) << FRAC_BITS) + DW'(root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr_r[0] <= num_nxt;
      dq_r[0] <= '0;
      dn_r[0] <= root;
      dg_r[0] <= sn_r[SQ];
      dz_r[0] <= (root == '0);
    end
  end

  // restoring division, quotient bit NQ-1-m at stage m
  for (genvar m = 0; m < NQ; m++) begin : g_div
    localparam int S = NQ - 1 - m;
    logic [DW-1:0] dv;
    logic [2:0]    take;
    assign dv = DW'(dn_r[m]) << S;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        take[i] = dr_r[m][i] >= dv;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dr_r[m+1][i] <= take[i] ? dr_r[m][i] - dv : dr_r[m][i];
          dq_r[m+1][i] <= {dq_r[m][i][NQ-2:0], take[i]};
        end
        dn_r[m+1] <= dn_r[m];
        dg_r[m+1] <= dg_r[m];
        dz_r[m+1] <= dz_r[m];
      end
    end
  end

  // restore sign
  always_comb begin
    logic [QW-1:0] qm;
    qm = '0;
    for (int i = 0; i < 3; i++) begin
      qm       = {1'b0, dq_r[NQ][i]};
      q_nxt[i] = dg_r[NQ][i] ? -$signed(qm) : $signed(qm);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_e_r <= q_nxt;
      z_e_r <= dz_r[NQ];
    end
  end

  assign out_v    = vld_r[NL-1];
  assign out_side = side_r[NL-1];
  assign out_q    = q_e_r;
  assign out_zero = z_e_r;

endmodule

### hw/rtl/lav_proj.sv
// Removes the look component from up: p = up - round(d * w), d = round(up.w).
// Depends on lav_pkg. Four stages, shared enable; big p is scaled down by four.
module lav_proj #(
  parameter int FRAC_BITS = 16,
  parameter int SW        = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_v,
  input  logic signed [lav_pkg::IN_W-1:0]  in_up [3],
  input  logic signed [FRAC_BITS+1:0]      in_w [3],
  input  logic [SW-1:0]                    in_side,
  output logic                             out_v,
  output logic signed [lav_pkg::PROJ_W-1:0] out_p [3],
  output logic [SW-1:0]                    out_side
);

  localparam int IW   = lav_pkg::IN_W;
  localparam int QW   = FRAC_BITS + 2;
  localparam int P1W  = IW + QW;          // up_i * w_i
  localparam int SUMW = P1W + 2;
  localparam int DDW  = 36;               // rounded dot product
  localparam int P3W  = DDW + QW;
  localparam int RW   = P3W - FRAC_BITS;  // rounded d * w_i
  localparam int PW   = RW + 1;
  localparam int OW   = lav_pkg::PROJ_W;
  localparam logic signed [SUMW-1:0] HALF1 = SUMW'(1) << (FRAC_BITS - 1);
  localparam logic signed [P3W-1:0]  HALF3 = P3W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0]   LIM   = PW'(1) << 31;

  logic [3:0]               vld_r;
  logic [SW-1:0]            side_r [4];

  logic signed [P1W-1:0]    pr1_nxt [3];
  logic signed [P1W-1:0]    pr1_r [3];
  logic signed [IW-1:0]     up1_r [3];
  logic signed [IW-1:0]     up2_r [3];
  logic signed [IW-1:0]     up3_r [3];
  logic signed [QW-1:0]     w1_r [3];
  logic signed [QW-1:0]     w2_r [3];
  logic signed [DDW-1:0]    d2_nxt, d2_r;
  logic signed [P3W-1:0]    dw3_nxt [3];
  logic signed [P3W-1:0]    dw3_r [3];
  logic signed [OW-1:0]     p4_nxt [3];
  logic signed [OW-1:0]     p4_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int i = 1; i < 4; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // stage 1: up_i * w_i
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr1_nxt[i] = in_up[i] * in_w[i];
    end
  end

  // stage 2: rounded dot product
  always_comb begin
    logic signed [SUMW-1:0] s;
    logic signed [SUMW-1:0] t;
    s      = pr1_r[0] + pr1_r[1] + pr1_r[2];
    t      = (s + HALF1) >>> FRAC_BITS;
    d2_nxt = t[DDW-1:0];
  end

  // stage 3: d * w_i
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dw3_nxt[i] = d2_r * w2_r[i];
    end
  end

  // stage 4: subtract, then scale down by four if any part is too large
  always_comb begin
    logic signed [P3W-1:0] t;
    logic signed [PW-1:0]  p [3];
    logic signed [PW-1:0]  ps;
    logic                  big;
    t   = '0;
    ps  = '0;
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      t    = (dw3_r[i] + HALF3) >>> FRAC_BITS;
      p[i] = PW'(up3_r[i]) - $signed(t[RW-1:0]);
      if (p[i] >= LIM || p[i] <= -LIM) begin
        big = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      ps        = big ? (p[i] >>> 2) : p[i];
      p4_nxt[i] = ps[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr1_r <= pr1_nxt;
      up1_r <= in_up;
      w1_r  <= in_w;
      d2_r  <= d2_nxt;
      up2_r <= up1_r;
      w2_r  <= w1_r;
      dw3_r <= dw3_nxt;
      up3_r <= up2_r;
      p4_r  <= p4_nxt;
    end
  end

  assign out_v    = vld_r[3];
  assign out_side = side_r[3];
  assign out_p    = p4_r;

endmodule

### hw/rtl/lav_rows.sv
// Builds u = v x w and the translation column -b.eye for rows 0..2.
// Depends on lav_pkg. Four stages under the shared enable.
module lav_rows #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_v,
  input  logic signed [FRAC_BITS+1:0]     in_vb [3],
  input  logic signed [FRAC_BITS+1:0]     in_wb [3],
  input  logic signed [lav_pkg::IN_W-1:0] in_eye [3],
  input  logic                            in_deg,
  output logic                            out_v,
  output lav_pkg::row_t [2:0]             out_rows,
  output logic                            out_deg
);

  localparam int IW  = lav_pkg::IN_W;
  localparam int QW  = FRAC_BITS + 2;
  localparam int CW  = 2 * QW;           // v_j * w_k
  localparam int DFW = CW + 1;
  localparam int UW  = FRAC_BITS + 4;
  localparam int EW  = IW + UW;          // eye_j * b_j
  localparam int SSW = EW + 2;
  localparam int EN_W = lav_pkg::ENTRY_W;
  localparam logic signed [DFW-1:0] HALFU = DFW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SSW-1:0] HALFE = SSW'(1) << (FRAC_BITS - 1);

  logic [3:0]              vld_r;
  logic                    deg_r [4];

  logic signed [CW-1:0]    c1_nxt [6];
  logic signed [CW-1:0]    c1_r [6];
  logic signed [QW-1:0]    v1_r [3], v2_r [3], v3_r [3];
  logic signed [QW-1:0]    w1_r [3], w2_r [3], w3_r [3];
  logic signed [IW-1:0]    eye1_r [3], eye2_r [3];
  logic signed [UW-1:0]    u2_nxt [3];
  logic signed [UW-1:0]    u2_r [3], u3_r [3];
  logic signed [EW-1:0]    e3_nxt [3][3];
  logic signed [EW-1:0]    e3_r [3][3];
  lav_pkg::row_t [2:0]     rows_nxt, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_v};
    end
  end

  // stage 1: cross product terms
  always_comb begin
    c1_nxt[0] = in_vb[1] * in_wb[2];
    c1_nxt[1] = in_vb[2] * in_wb[1];
    c1_nxt[2] = in_vb[2] * in_wb[0];
    c1_nxt[3] = in_vb[0] * in_wb[2];
    c1_nxt[4] = in_vb[0] * in_wb[1];
    c1_nxt[5] = in_vb[1] * in_wb[0];
  end

  // stage 2: rounded differences give u
  always_comb begin
    logic signed [DFW-1:0] t;
    t = '0;
    for (int i = 0; i < 3; i++) begin
      t         = (DFW'(c1_r[2*i]) - DFW'(c1_r[2*i+1]) + HALFU) >>> FRAC_BITS;
      u2_nxt[i] = t[UW-1:0];
    end
  end

  // stage 3: eye products for each basis vector
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      e3_nxt[0][j] = eye2_r[j] * u2_r[j];
      e3_nxt[1][j] = eye2_r[j] * UW'(v2_r[j]);
      e3_nxt[2][j] = eye2_r[j] * UW'(w2_r[j]);
    end
  end

  // stage 4: translation term and row assembly; a degenerate basis gives zeros
  always_comb begin
    logic signed [SSW-1:0] s;
    logic signed [SSW-1:0] t;
    s = '0;
    t = '0;
    rows_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      s = SSW'(e3_r[r][0]) + SSW'(e3_r[r][1]) + SSW'(e3_r[r][2]);
      t = -((s + HALFE) >>> FRAC_BITS);
      rows_nxt[r].e3 = t[EN_W-1:0];
    end
    rows_nxt[0].e0 = lav_pkg::entry_t'(u3_r[0]);
    rows_nxt[0].e1 = lav_pkg::entry_t'(u3_r[1]);
    rows_nxt[0].e2 = lav_pkg::entry_t'(u3_r[2]);
    rows_nxt[1].e0 = lav_pkg::entry_t'(v3_r[0]);
    rows_nxt[1].e1 = lav_pkg::entry_t'(v3_r[1]);
    rows_nxt[1].e2 = lav_pkg::entry_t'(v3_r[2]);
    rows_nxt[2].e0 = lav_pkg::entry_t'(w3_r[0]);
    rows_nxt[2].e1 = lav_pkg::entry_t'(w3_r[1]);
    rows_nxt[2].e2 = lav_pkg::entry_t'(w3_r[2]);
    if (deg_r[2]) begin
      rows_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= c1_nxt;
      v1_r   <= in_vb;
      w1_r   <= in_wb;
      eye1_r <= in_eye;
      deg_r[0] <= in_deg;
      u2_r   <= u2_nxt;
      v2_r   <= v1_r;
      w2_r   <= w1_r;
      eye2_r <= eye1_r;
      deg_r[1] <= deg_r[0];
      e3_r   <= e3_nxt;
      u3_r   <= u2_r;
      v3_r   <= v2_r;
      w3_r   <= w2_r;
      deg_r[2] <= deg_r[1];
      rows_r <= rows_nxt;
      deg_r[3] <= deg_r[2];
    end
  end

  assign out_v    = vld_r[3];
  assign out_rows = rows_r;
  assign out_deg  = deg_r[3];

endmodule

### hw/rtl/look_at_view_matrix.sv
// Look-at view matrix: camera basis and translation, four rows per camera.
// Top level; depends on lav_pkg, lav_norm, lav_proj and lav_rows.
//
// Usage: one beat on the in_ channel carries a camera (look, up, eye, each
// signed fixed point with FRAC_BITS fraction bits). It produces four beats on
// the out_ channel, rows 0 to 3 in order; out_last_row marks row 3 and
// out_degenerate marks a zero-length look or an up vector parallel to look,
// in which case every entry is zero.
// The path from input beat to row 0 runs through two normalizers, each a
// 32-stage root followed by a FRAC_BITS+1 stage divider, then the projection
// and row stages. The output row serializer holds one finished camera while
// the pipeline keeps filling behind it, and loads the next camera as the
// last row of the held one is accepted.
// Reset (rst_n low, synchronous) empties every stage and the serializer.
// When the receiver stalls, the serializer holds its row and, once the last
// pipeline stage is also occupied, the whole pipeline freezes and in_ready
// drops; nothing is lost or repeated.
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [lav_pkg::IN_W-1:0]  in_look_x,
  input  logic signed [lav_pkg::IN_W-1:0]  in_look_y,
  input  logic signed [lav_pkg::IN_W-1:0]  in_look_z,
  input  logic signed [lav_pkg::IN_W-1:0]  in_up_x,
  input  logic signed [lav_pkg::IN_W-1:0]  in_up_y,
  input  logic signed [lav_pkg::IN_W-1:0]  in_up_z,
  input  logic signed [lav_pkg::IN_W-1:0]  in_eye_x,
  input  logic signed [lav_pkg::IN_W-1:0]  in_eye_y,
  input  logic signed [lav_pkg::IN_W-1:0]  in_eye_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lav_pkg::ROW_W-1:0]        out_row_index,
  output logic signed [lav_pkg::ENTRY_W-1:0] out_entry_0,
  output logic signed [lav_pkg::ENTRY_W-1:0] out_entry_1,
  output logic signed [lav_pkg::ENTRY_W-1:0] out_entry_2,
  output logic signed [lav_pkg::ENTRY_W-1:0] out_entry_3,
  output logic                             out_last_row,
  output logic                             out_degenerate
);

  localparam int IW  = lav_pkg::IN_W;
  localparam int QW  = FRAC_BITS + 2;
  localparam int WSW = 6 * IW;              // up and eye beside the w normalizer
  localparam int PSW = 3 * QW + 3 * IW + 1; // w, eye, w degenerate
  localparam lav_pkg::entry_t ONE_E = lav_pkg::ENTRY_W'(1) << FRAC_BITS;

  logic                         en;

  logic signed [IW:0]           look_neg [3];
  logic                         w_v, w_zero;
  logic signed [QW-1:0]         w_q [3];
  logic [WSW-1:0]               w_side;
  logic signed [IW-1:0]         up_w [3];
  logic signed [IW-1:0]         eye_w [3];

  logic                         p_v;
  logic signed [lav_pkg::PROJ_W-1:0] p_p [3];
  logic [PSW-1:0]               p_side_in, p_side;

  logic                         v_v, v_zero;
  logic signed [QW-1:0]         v_q [3];
  logic [PSW-1:0]               v_side;
  logic signed [QW-1:0]         w_v_q [3];
  logic signed [IW-1:0]         eye_v [3];

  logic                         rows_v, rows_deg;
  lav_pkg::row_t [2:0]          rows;

  logic                         ser_v_r, ser_v_nxt;
  lav_pkg::row_idx_t            cnt_r, cnt_nxt;
  lav_pkg::row_t [2:0]          rows_r;
  logic                         deg_r;
  logic                         ser_take;
  lav_pkg::row_t                row_out;

  // global pipeline advance
  assign ser_take = !ser_v_r || (out_ready && cnt_r == lav_pkg::ROW_LAST);
  assign en       = !rows_v || ser_take;
  assign in_ready = en;

  // w = normalize(-look)
  assign look_neg[0] = -(IW + 1)'(in_look_x);
  assign look_neg[1] = -(IW + 1)'(in_look_y);
  assign look_neg[2] = -(IW + 1)'(in_look_z);

  lav_norm #(
    .FRAC_BITS (FRAC_BITS),
    .AW        (IW + 1),
    .SW        (WSW)
  ) u_norm_w (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_valid),
    .in_a     (look_neg),
    .in_side  ({in_up_x, in_up_y, in_up_z, in_eye_x, in_eye_y, in_eye_z}),
    .out_v    (w_v),
    .out_q    (w_q),
    .out_zero (w_zero),
    .out_side (w_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up_w[i]  = w_side[(6 - i) * IW - 1 -: IW];
      eye_w[i] = w_side[(3 - i) * IW - 1 -: IW];
    end
  end

  // projected up
  assign p_side_in = {w_q[0], w_q[1], w_q[2], eye_w[0], eye_w[1], eye_w[2], w_zero};

  lav_proj #(
    .FRAC_BITS (FRAC_BITS),
    .SW        (PSW)
  ) u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (w_v),
    .in_up    (up_w),
    .in_w     (w_q),
    .in_side  (p_side_in),
    .out_v    (p_v),
    .out_p    (p_p),
    .out_side (p_side)
  );

  // v = normalize(p)
  lav_norm #(
    .FRAC_BITS (FRAC_BITS),
    .AW        (lav_pkg::PROJ_W),
    .SW        (PSW)
  ) u_norm_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (p_v),
    .in_a     (p_p),
    .in_side  (p_side),
    .out_v    (v_v),
    .out_q    (v_q),
    .out_zero (v_zero),
    .out_side (v_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_v_q[i] = v_side[PSW - 1 - i * QW -: QW];
      eye_v[i] = v_side[3 * IW - i * IW -: IW];
    end
  end

  // basis cross product and translation
  lav_rows #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rows (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v_v),
    .in_vb    (v_q),
    .in_wb    (w_v_q),
    .in_eye   (eye_v),
    .in_deg   (v_side[0] | v_zero),
    .out_v    (rows_v),
    .out_rows (rows),
    .out_deg  (rows_deg)
  );

  // row serializer
  always_comb begin
    ser_v_nxt = ser_v_r;
    cnt_nxt   = cnt_r;
    if (out_valid && out_ready) begin
      if (cnt_r == lav_pkg::ROW_LAST) begin
        ser_v_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 2'd1;
      end
    end
    if (en && rows_v) begin
      ser_v_nxt = 1'b1;
      cnt_nxt   = lav_pkg::ROW_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      cnt_r   <= lav_pkg::ROW_FIRST;
    end else begin
      ser_v_r <= ser_v_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && rows_v) begin
      rows_r <= rows;
      deg_r  <= rows_deg;
    end
  end

  // output row select; the last row is 0 0 0 1, or all zero for a degenerate camera
  always_comb begin
    if (cnt_r == lav_pkg::ROW_LAST) begin
      row_out    = '0;
      row_out.e3 = deg_r ? '0 : ONE_E;
    end else begin
      row_out = rows_r[cnt_r];
    end
  end

  assign out_valid      = ser_v_r;
  assign out_row_index  = cnt_r;
  assign out_entry_0    = row_out.e0;
  assign out_entry_1    = row_out.e1;
  assign out_entry_2    = row_out.e2;
  assign out_entry_3    = row_out.e3;
  assign out_last_row   = (cnt_r == lav_pkg::ROW_LAST);
  assign out_degenerate = deg_r;

`ifndef SYNTHESIS
  // rows step by one on each accepted beat short of the last row
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_row_index != lav_pkg::ROW_LAST) |=>
      out_valid && (out_row_index == $past(out_row_index) + 2'd1))
    else $error("row index did not advance");

  // a degenerate camera carries only zero entries
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_entry_0 == '0) && (out_entry_1 == '0) &&
      (out_entry_2 == '0) && (out_entry_3 == '0))
    else $error("degenerate row has nonzero entry");

  // a camera leaving the pipeline starts at row 0
  a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
    en && rows_v |=> out_valid && (out_row_index == lav_pkg::ROW_FIRST))
    else $error("serializer load did not start at row 0");
`endif

endmodule

### sim/look_at_view_matrix_checker.sv
// Checker for the look-at view matrix: watches both channels, predicts the
// four rows of each accepted camera and compares them. Depends on lav_pkg.
module look_at_view_matrix_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [lav_pkg::IN_W-1:0]    in_look_x,
  input  logic signed [lav_pkg::IN_W-1:0]    in_look_y,
  input  logic signed [lav_pkg::IN_W-1:0]    in_look_z,
  input  logic signed [lav_pkg::IN_W-1:0]    in_up_x,
  input  logic signed [lav_pkg::IN_W-1:0]    in_up_y,
  input  logic signed [lav_pkg::IN_W-1:0]    in_up_z,
  input  logic signed [lav_pkg::IN_W-1:0]    in_eye_x,
  input  logic signed [lav_pkg::IN_W-1:0]    in_eye_y,
  input  logic signed [lav_pkg::IN_W-1:0]    in_eye_z,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [lav_pkg::ROW_W-1:0]          out_row_index,
  input  logic signed [lav_pkg::ENTRY_W-1:0] out_entry_0,
  input  logic signed [lav_pkg::ENTRY_W-1:0] out_entry_1,
  input  logic signed [lav_pkg::ENTRY_W-1:0] out_entry_2,
  input  logic signed [lav_pkg::ENTRY_W-1:0] out_entry_3,
  input  logic                               out_last_row,
  input  logic                               out_degenerate,
  output int                                 errors,
  output int                                 rows_pending
);

  typedef struct {
    lav_pkg::row_idx_t idx;
    lav_pkg::entry_t   e[4];
    logic              last;
    logic              degen;
  } mat_row_t;

  typedef logic signed [63:0] s64_t;

  mat_row_t row_q[$];

  assign rows_pending = row_q.size();

  function automatic s64_t floor_shr(s64_t x, int s);
    return x >>> s;
  endfunction

  function automatic s64_t round_frac(s64_t x);
    return (x + (s64_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // unit vector with halves rounded away from zero; returns 0 on zero length
  function automatic logic unit_vec(input s64_t a[3], output s64_t o[3]);
    logic [63:0] sum, n, m, q;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = a[i] < 0 ? -a[i] : a[i];
      sum += m * m;
    end
    o = '{0, 0, 0};
    if (sum == 0) return 1'b0;
    n = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      m = a[i] < 0 ? -a[i] : a[i];
      q = ((m << FRAC_BITS) + n / 2) / n;
      o[i] = a[i] < 0 ? -s64_t'(q) : s64_t'(q);
    end
    return 1'b1;
  endfunction

  function automatic s64_t dot_frac(s64_t a[3], s64_t b[3]);
    return round_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
  endfunction

  function automatic lav_pkg::entry_t clamp(s64_t x);
    if (x > 64'sd549755813887) return 40'sh7F_FFFF_FFFF;
    if (x < -64'sd549755813888) return 40'sh80_0000_0000;
    return lav_pkg::entry_t'(x);
  endfunction

  // build the camera basis and push the four expected rows
  task automatic predict_camera(s64_t lk[3], s64_t up[3], s64_t eye[3]);
    s64_t nl[3], w[3], p[3], v[3], u[3];
    s64_t m[4][4];
    s64_t d;
    logic ok, big;
    mat_row_t r;
    for (int i = 0; i < 3; i++) nl[i] = -lk[i];
    ok = unit_vec(nl, w);
    v = '{0, 0, 0};
    if (ok) begin
      d = dot_frac(up, w);
      big = 1'b0;
      for (int i = 0; i < 3; i++) begin
        p[i] = up[i] - round_frac(d * w[i]);
        if (p[i] >= (s64_t'(1) <<< 31) || p[i] <= -(s64_t'(1) <<< 31)) big = 1'b1;
      end
      if (big) for (int i = 0; i < 3; i++) p[i] = floor_shr(p[i], 2);
      ok = unit_vec(p, v);
    end
    for (int a = 0; a < 4; a++) for (int b = 0; b < 4; b++) m[a][b] = 0;
    if (ok) begin
      u[0] = round_frac(v[1] * w[2] - v[2] * w[1]);
      u[1] = round_frac(v[2] * w[0] - v[0] * w[2]);
      u[2] = round_frac(v[0] * w[1] - v[1] * w[0]);
      for (int i = 0; i < 3; i++) begin
        m[0][i] = u[i];
        m[1][i] = v[i];
        m[2][i] = w[i];
      end
      m[0][3] = -dot_frac(u, eye);
      m[1][3] = -dot_frac(v, eye);
      m[2][3] = -dot_frac(w, eye);
      m[3][3] = s64_t'(1) <<< FRAC_BITS;
    end
    for (int a = 0; a < 4; a++) begin
      r.idx = lav_pkg::row_idx_t'(a);
      for (int b = 0; b < 4; b++) r.e[b] = clamp(m[a][b]);
      r.last = (r.idx == lav_pkg::ROW_LAST);
      r.degen = !ok;
      row_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  initial errors = 0;

  // input beats feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      predict_camera('{in_look_x, in_look_y, in_look_z}, '{in_up_x, in_up_y, in_up_z},
                     '{in_eye_x, in_eye_y, in_eye_z});
  end

  // output beats compared with the oldest expected row
  always @(posedge clk) begin
    mat_row_t x;
    if (rst_n && out_valid && out_ready) begin
      if (row_q.size() == 0) begin
        report_mismatch("unexpected row beat", out_row_index, -1);
      end else begin
        x = row_q.pop_front();
        if (out_row_index !== x.idx) report_mismatch("row_index", out_row_index, x.idx);
        if (out_entry_0 !== x.e[0]) report_mismatch("entry_0", out_entry_0, x.e[0]);
        if (out_entry_1 !== x.e[1]) report_mismatch("entry_1", out_entry_1, x.e[1]);
        if (out_entry_2 !== x.e[2]) report_mismatch("entry_2", out_entry_2, x.e[2]);
        if (out_entry_3 !== x.e[3]) report_mismatch("entry_3", out_entry_3, x.e[3]);
        if (out_last_row !== x.last) report_mismatch("last_row", out_last_row, x.last);
        if (out_degenerate !== x.degen)
          report_mismatch("degenerate", out_degenerate, x.degen);
      end
    end
  end
endmodule

### sim/look_at_view_matrix_tb.sv
// Testbench top for the look-at view matrix: clock, reset, camera stimulus,
// receiver stalls and verdict. Depends on lav_pkg, the block and its checker.
module look_at_view_matrix_tb;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY   = 2 * FRAC_BITS + 100;
  localparam int IDLE_MAX  = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [lav_pkg::IN_W-1:0] cam [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [lav_pkg::ROW_W-1:0] out_row_index;
  logic signed [lav_pkg::ENTRY_W-1:0] out_entry_0, out_entry_1, out_entry_2, out_entry_3;
  logic out_last_row, out_degenerate;
  int errors, rows_pending;
  int idle_cycles = 0;
  logic hold_out = 1'b0;

  initial for (int i = 0; i < 9; i++) cam[i] = '0;

  always #6 clk = ~clk;

  look_at_view_matrix #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_look_x(cam[0]), .in_look_y(cam[1]), .in_look_z(cam[2]),
    .in_up_x(cam[3]), .in_up_y(cam[4]), .in_up_z(cam[5]),
    .in_eye_x(cam[6]), .in_eye_y(cam[7]), .in_eye_z(cam[8]),
    .out_valid(out_valid), .out_ready(out_ready), .out_row_index(out_row_index),
    .out_entry_0(out_entry_0), .out_entry_1(out_entry_1), .out_entry_2(out_entry_2),
    .out_entry_3(out_entry_3), .out_last_row(out_last_row),
    .out_degenerate(out_degenerate)
  );

  look_at_view_matrix_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_look_x(cam[0]), .in_look_y(cam[1]), .in_look_z(cam[2]),
    .in_up_x(cam[3]), .in_up_y(cam[4]), .in_up_z(cam[5]),
    .in_eye_x(cam[6]), .in_eye_y(cam[7]), .in_eye_z(cam[8]),
    .out_valid(out_valid), .out_ready(out_ready), .out_row_index(out_row_index),
    .out_entry_0(out_entry_0), .out_entry_1(out_entry_1), .out_entry_2(out_entry_2),
    .out_entry_3(out_entry_3), .out_last_row(out_last_row),
    .out_degenerate(out_degenerate), .errors(errors), .rows_pending(rows_pending)
  );

  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(60, 15);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(3);
  endfunction

  // random component: full range, small vectors, or extremes
  function automatic logic signed [31:0] rnd_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      3: return 32'($signed($urandom_range(4000)) - 2000);
      default: return 32'($signed($urandom_range(2 << 20)) - (1 << 20));
    endcase
  endfunction

  // send one camera beat after a gap; valid stays high when no gap follows
  task automatic send_camera(logic signed [31:0] c[9]);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) cam[i] <= c[i];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rows_pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_out = 1'b0;
      end
      g = ($urandom_range(3) == 0) ? 0 : gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] c[9];
    logic signed [31:0] mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: canonical, zero look, parallel up, extremes, large projection
    send_camera('{0, 0, -65536, 0, 65536, 0, 0, 0, 65536});
    send_camera('{0, 0, 0, 0, 65536, 0, 100, 200, 300});
    send_camera('{0, 0, 0, mx, mn, mx, mx, mn, mx});
    send_camera('{0, 65536, 0, 0, 3 << 16, 0, 5, 6, 7});
    send_camera('{0, -65536, 0, 0, mn, 0, 5, 6, 7});
    send_camera('{mx, mx, mx, mn, mx, mn, mx, mx, mx});
    send_camera('{mn, mn, mn, mx, mn, mx, mn, mn, mn});
    send_camera('{mx, 0, 0, 0, mx, mx, mn, mn, mn});
    send_camera('{mn, 0, 0, 0, mn, mn, mx, mx, mx});
    send_camera('{1, 0, 0, 0, 1, 0, -1, -1, -1});
    send_camera('{-1, -1, -1, 1, -1, 0, 0, 0, 0});
    send_camera('{0, 0, 1, mx, mx, 0, 12345, -12345, 1});
    send_camera('{mx, mx, mx, mx, mx, mx, 0, 0, 0});
    send_camera('{65536, 65536, 0, mn, mx, mn, mx, mn, 0});
    send_camera('{-32768, 98304, 7, 0, 0, mx, -mx, 3, -3});

    // sender waits for the block to drain completely
    wait_drained();
    repeat (LATENCY) @(posedge clk);

    // random cameras; one long receiver hold-off partway through
    for (int n = 0; n < 110; n++) begin
      if (n == 30) hold_out = 1'b1;
      for (int i = 0; i < 9; i++) c[i] = rnd_comp();
      if ($urandom_range(19) == 0) c[0:2] = '{0, 0, 0};
      else if ($urandom_range(19) == 0) c[3:5] = '{c[0], c[1], c[2]};
      send_camera(c);
    end

    wait_drained();
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
